FILE: sv/sakv_pkg.sv
// Shared types and codes for the sorted key/value table.
`default_nettype none
package sakv_pkg;

    // Operation codes carried in the request.
    localparam logic [2:0] FN_INSERT     = 3'd0;
    localparam logic [2:0] FN_FIND_KEY   = 3'd1;
    localparam logic [2:0] FN_FIND_VALUE = 3'd2;
    localparam logic [2:0] FN_READ_INDEX = 3'd3;
    localparam logic [2:0] FN_CLEAR      = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_UPDATED       = 3'd0;
    localparam logic [2:0] ST_INSERTED      = 3'd1;
    localparam logic [2:0] ST_FULL          = 3'd2;
    localparam logic [2:0] ST_FOUND         = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND     = 3'd4;
    localparam logic [2:0] ST_CLEARED       = 3'd5;
    localparam logic [2:0] ST_OUT_OF_BOUNDS = 3'd6;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] key_in;
        logic [31:0] value_in;
        logic [2:0]  index_in;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  position;
        logic [31:0] key_out;
        logic [31:0] value_out;
        logic [3:0]  entry_count;
    } t_rsp;

    // Memory port strobes from the sequencer.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS,
        S_FETCH,
        S_LOAD,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

FILE: sv/sakv_mem.sv
// Entry store: one write port and one read port with registered read data.
`default_nettype none
module sakv_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 64
) (
    input  wire                       i_clk,
    input  wire sakv_pkg::t_mem_cmd   i_cmd,
    input  wire [AW-1:0]              i_rd_addr,
    input  wire [AW-1:0]              i_wr_addr,
    input  wire [DW-1:0]              i_wr_data,
    output logic [DW-1:0]             o_rd_data
);
    import sakv_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/sakv_ctrl.sv
// Sequencer: scans, shifts and updates the entry store for one request at a time.
`default_nettype none
module sakv_ctrl #(
    parameter int CAPACITY    = 8,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 3,
    parameter int CW          = 4
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_req_valid,
    output logic                                  o_req_ready,
    input  wire sakv_pkg::t_req                   i_req,
    output logic                                  o_res_valid,
    input  wire                                   i_res_ready,
    output sakv_pkg::t_rsp                        o_res,
    output sakv_pkg::t_mem_cmd                    o_cmd,
    output logic [AW-1:0]                         o_rd_addr,
    output logic [AW-1:0]                         o_wr_addr,
    output logic [KEY_WIDTH+VALUE_WIDTH-1:0]      o_wr_data,
    input  wire  [KEY_WIDTH+VALUE_WIDTH-1:0]      i_rd_data
);
    import sakv_pkg::*;

    t_state                 r_state, n_state;
    logic [2:0]             r_func;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [CW-1:0]          r_idx;
    logic [AW-1:0]          r_cmp;
    logic                   r_chk;
    logic                   r_eq;
    logic [CW-1:0]          r_pos;
    logic [CW-1:0]          r_count;
    logic [2:0]             r_st;
    logic [3:0]             r_rpos;
    logic [KEY_WIDTH-1:0]   r_rkey;
    logic [VALUE_WIDTH-1:0] r_rval;

    logic [KEY_WIDTH-1:0]   w_rd_key;
    logic [VALUE_WIDTH-1:0] w_rd_val;
    logic                   w_match;
    logic                   w_hit;
    logic                   w_more;
    logic                   w_idx_ok;
    logic                   w_room;
    logic                   w_accept;

    assign w_rd_key = i_rd_data[KEY_WIDTH+VALUE_WIDTH-1:VALUE_WIDTH];
    assign w_rd_val = i_rd_data[VALUE_WIDTH-1:0];
    // Key searches stop at the first key not below the one sought.
    assign w_match  = (r_func == FN_FIND_VALUE) ? (w_rd_val == r_val) : (w_rd_key >= r_key);
    assign w_hit    = r_chk && w_match;
    assign w_more   = r_idx < r_count;
    assign w_idx_ok = 32'(i_req.index_in) < 32'(r_count);
    assign w_room   = 32'(r_count) < CAPACITY;
    assign w_accept = i_req_valid && o_req_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    case (i_req.func)
                        FN_INSERT, FN_FIND_KEY, FN_FIND_VALUE: n_state = S_SCAN;
                        FN_READ_INDEX: n_state = w_idx_ok ? S_FETCH : S_EMIT;
                        FN_CLEAR:      n_state = S_EMIT;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_hit || !w_more) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                if (r_func == FN_INSERT && !r_eq && w_room) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SHIFT_RD: n_state = (r_idx > r_pos) ? S_SHIFT_WR : S_INS;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_INS:      n_state = S_EMIT;
            S_FETCH:    n_state = S_LOAD;
            S_LOAD:     n_state = S_EMIT;
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs and memory strobes.
    always_comb begin
        o_req_ready  = (r_state == S_IDLE);
        o_res_valid  = (r_state == S_EMIT);
        o_cmd.rd_en  = 1'b0;
        o_cmd.wr_en  = 1'b0;
        o_rd_addr    = AW'(r_idx);
        o_wr_addr    = AW'(r_pos);
        o_wr_data    = {r_key, r_val};
        case (r_state)
            S_SCAN: begin
                o_cmd.rd_en = !w_hit && w_more;
            end
            S_RESOLVE: begin
                o_cmd.wr_en = (r_func == FN_INSERT) && r_eq;
            end
            S_SHIFT_RD: begin
                o_cmd.rd_en = r_idx > r_pos;
                o_rd_addr   = AW'(r_idx - 1'b1);
            end
            S_SHIFT_WR: begin
                // The lower neighbor moves up by one place.
                o_cmd.wr_en = 1'b1;
                o_wr_addr   = AW'(r_idx);
                o_wr_data   = i_rd_data;
            end
            S_INS: begin
                o_cmd.wr_en = 1'b1;
            end
            S_FETCH: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr   = AW'(r_pos);
            end
            default: begin
                o_cmd.rd_en = 1'b0;
            end
        endcase
    end

    assign o_res.status      = r_st;
    assign o_res.position    = r_rpos;
    assign o_res.key_out     = 32'(r_rkey);
    assign o_res.value_out   = 32'(r_rval);
    assign o_res.entry_count = 4'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_req.func == FN_CLEAR) begin
                        r_count <= '0;
                    end
                    r_chk <= 1'b0;
                end
                S_SCAN: begin
                    r_chk <= !w_hit && w_more;
                end
                S_INS: begin
                    r_count <= r_count + 1'b1;
                end
                default: begin
                    r_chk <= 1'b0;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_func <= i_req.func;
                    r_key  <= KEY_WIDTH'(i_req.key_in);
                    r_val  <= VALUE_WIDTH'(i_req.value_in);
                    r_idx  <= '0;
                    r_pos  <= CW'(i_req.index_in);
                    r_rkey <= '0;
                    r_rval <= '0;
                    r_rpos <= 4'(i_req.index_in);
                    r_st   <= (i_req.func == FN_CLEAR) ? ST_CLEARED : ST_OUT_OF_BOUNDS;
                    if (i_req.func == FN_CLEAR) begin
                        r_rpos <= '0;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    r_pos <= CW'(r_cmp);
                    r_eq  <= (r_func == FN_FIND_VALUE) || (w_rd_key == r_key);
                end else if (w_more) begin
                    r_cmp <= AW'(r_idx);
                    r_idx <= r_idx + 1'b1;
                end else begin
                    // Past the end: the key or value sought is absent.
                    r_pos <= r_count;
                    r_eq  <= 1'b0;
                end
            end
            S_RESOLVE: begin
                r_idx <= r_count;
                if (r_eq) begin
                    r_st   <= (r_func == FN_INSERT) ? ST_UPDATED : ST_FOUND;
                    r_rpos <= 4'(r_pos);
                    r_rkey <= (r_func == FN_INSERT) ? r_key : w_rd_key;
                    r_rval <= (r_func == FN_INSERT) ? r_val : w_rd_val;
                end else begin
                    r_st   <= (r_func == FN_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    r_rpos <= 4'(r_count);
                    r_rkey <= '0;
                    r_rval <= '0;
                end
            end
            S_SHIFT_WR: begin
                r_idx <= r_idx - 1'b1;
            end
            S_INS: begin
                r_st   <= ST_INSERTED;
                r_rpos <= 4'(r_pos);
                r_rkey <= r_key;
                r_rval <= r_val;
            end
            S_LOAD: begin
                r_st   <= ST_FOUND;
                r_rpos <= 4'(r_pos);
                r_rkey <= w_rd_key;
                r_rval <= w_rd_val;
            end
            default: begin
                r_func <= r_func;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/sorted_array_key_value_table_core.sv
// Sorted key/value table top level: sequencer, entry store and output register.
//
// Holds up to CAPACITY key/value pairs in ascending key order in one
// synchronous memory. One request is worked on at a time. A search reads one
// entry per cycle. A find, or an insert that updates an existing key, reads
// each held entry at most once. An insert of a new key moves each larger
// entry up (one read and one write of the memory) and then writes the new
// entry. The search stops at the insertion point, so an insert at the head
// takes the longest. Read by index reads the memory once; clear and
// out-of-bounds reads need no memory access. Unknown operation codes are
// taken and produce no result. A finished result waits in an output register,
// and the next request is taken while it waits.
`default_nettype none
module sorted_array_key_value_table_core #(
    parameter int CAPACITY    = 8,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire sakv_pkg::t_req  i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output sakv_pkg::t_rsp       o_out_data
);
    import sakv_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = KEY_WIDTH + VALUE_WIDTH;

    t_mem_cmd      w_cmd;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic [DW-1:0] w_wr_data;
    logic [DW-1:0] w_rd_data;
    logic          w_res_valid;
    logic          w_res_ready;
    t_rsp          w_res;

    logic          r_out_valid;
    t_rsp          r_out;

    sakv_ctrl #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_req       (i_in_data),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .i_rd_data   (w_rd_data)
    );

    sakv_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // The output register takes a new result whenever it is empty or being drained.
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: sv/sakv_checker.sv
// Port-level checks for the sorted key/value table, bound to the top level.
`default_nettype none
module sakv_checker #(
    parameter int CAPACITY = 8
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_ready,
    input wire sakv_pkg::t_req  i_in_data,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input wire sakv_pkg::t_rsp  o_out_data
);
    import sakv_pkg::*;

    // A result that is not taken holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_CLEARED |->
            o_out_data.entry_count == 4'd0 && o_out_data.position == 4'd0)
        else $error("clear left entries");

    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_NOT_FOUND || o_out_data.status == ST_FULL) |->
            o_out_data.position == o_out_data.entry_count && o_out_data.key_out == 32'd0
            && o_out_data.value_out == 32'd0)
        else $error("miss result does not report the entry count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && CAPACITY < 16 |-> 32'(o_out_data.entry_count) <= CAPACITY)
        else $error("entry count above capacity");

endmodule

bind sorted_array_key_value_table_core sakv_checker #(.CAPACITY(CAPACITY)) u_sakv_checker (.*);
`default_nettype wire
